// ===== rtl/pcc_pkg.sv =====
// Shared types, constants and the error classifier of the post code capture buffer.
// Used by the core, queue, front and back modules; depends on nothing else.
package pcc_pkg;

    localparam int unsigned PCC_RING_DEPTH  = 256;
    localparam int unsigned PCC_MAX_READ    = 64;
    localparam int unsigned PCC_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_SNOOP    = 2'd0,
        CMD_READ     = 2'd1,
        CMD_CLR_LEN  = 2'd2,
        CMD_CLR_SEEN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CODE  = 2'd0,
        KIND_HIST  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_PSB     = 2'd1,
        ERR_ABL     = 2'd2,
        ERR_ABL_MEM = 2'd3
    } t_err;

    localparam logic [3:0]  LANE_LAST      = 4'd3;
    localparam logic [15:0] ABL_MEM_CODE   = 16'hE310;
    localparam logic [15:0] PSB_PREFIX_RST = 16'hEE00;
    localparam logic [15:0] ABL_PREFIX_RST = 16'hEA00;

    localparam int unsigned PSB_N = 28;
    localparam int unsigned ABL_N = 48;

    localparam logic [7:0] PSB_FAIL [PSB_N] = '{
        8'h03, 8'h04, 8'h05, 8'h0B, 8'h10, 8'h13, 8'h14, 8'h18, 8'h22, 8'h3E,
        8'h62, 8'h64, 8'h69, 8'h6C, 8'h6F, 8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C,
        8'h7D, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h92
    };

    localparam logic [15:0] ABL_FAIL [ABL_N] = '{
        16'h3000, 16'h3001, 16'h3002, 16'h3003, 16'hE2A4, 16'hE2A7, 16'hE2A8,
        16'hE2AA, 16'hE2AB, 16'hE2AC, 16'hE2AE, 16'hE2B1, 16'hE2B2, 16'hE2E4,
        16'hE2B3, 16'hE2B4, 16'hE2B5, 16'hE2B9, 16'hE2BA, 16'hE2BB, 16'hE2BD,
        16'hE2BF, 16'hE2CB, 16'hE2CC, 16'hE2CD, 16'hE320, 16'hE321, 16'hE322,
        16'hE2E5, 16'hE2EB, 16'hE2EC, 16'hE2AD, 16'hE2ED, 16'hE30E, 16'hE2CA,
        16'hE2EF, 16'hE2C2, 16'hE2C3, 16'hE2E3, 16'hE2C6, 16'hE310, 16'hE2E7,
        16'hE32D, 16'hE33E, 16'hE328, 16'hE345, 16'hE32B, 16'hE332
    };

    typedef struct packed {
        t_kind       kind;
        logic [31:0] code;
        logic [7:0]  start;
        logic [6:0]  count;
        logic [8:0]  hist;
        logic        seen;
    } t_job;

    typedef struct packed {
        t_err        cls;
        logic [15:0] ecode;
    } t_cls;

    function automatic t_cls classify(input logic [31:0] code, input logic [15:0] psb,
                                      input logic [15:0] abl);
        t_cls res;
        logic psb_hit;
        logic abl_hit;
        psb_hit   = 1'b0;
        abl_hit   = 1'b0;
        res.cls   = ERR_NONE;
        res.ecode = '0;
        for (int k = 0; k < PSB_N; k++) begin
            if (PSB_FAIL[k] == code[7:0]) begin
                psb_hit = 1'b1;
            end
        end
        for (int k = 0; k < ABL_N; k++) begin
            if (ABL_FAIL[k] == code[15:0]) begin
                abl_hit = 1'b1;
            end
        end
        if (code[31:16] == psb) begin
            if (psb_hit) begin
                res.cls   = ERR_PSB;
                res.ecode = {8'h00, code[7:0]};
            end
        end else if (code[31:16] == abl && abl_hit) begin
            res.cls   = (code[15:0] == ABL_MEM_CODE) ? ERR_ABL_MEM : ERR_ABL;
            res.ecode = code[15:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/pcc_if.sv =====
// Valid/ready channel interfaces for the command beats and the result beats.
// Standalone; widths follow the fixed field widths of the block.
interface pcc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] snoop_byte;
    logic [3:0] port_index;
    logic [7:0] read_start;
    logic [6:0] read_count;

    modport source (output valid, cmd, snoop_byte, port_index, read_start, read_count,
                    input ready);
    modport sink (input valid, cmd, snoop_byte, port_index, read_start, read_count,
                  output ready);
endinterface

interface pcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] code_word;
    logic [1:0]  error_class;
    logic [15:0] err_code;
    logic [8:0]  history_length;
    logic        seen_flag;
    logic        last;

    modport source (output valid, kind, code_word, error_class, err_code, history_length,
                    seen_flag, last, input ready);
    modport sink (input valid, kind, code_word, error_class, err_code, history_length,
                  seen_flag, last, output ready);
endinterface

// ===== rtl/post_code_capture_buffer_core.sv =====
// A completed post code passes through the job queue, the job register, the data stage and
// the output register to o_out. Throughput: one command beat per cycle while the job queue
// has room; a history read returns one entry per cycle through the ring's registered read
// port while o_out is not stalled, and a lane-3 beat waits while a history read is still
// outstanding. Reset is synchronous, active low: accumulator, ring pointer, stored length and
// seen flag clear, the prefixes return to 0xEE00 and 0xEA00; ring contents are not cleared.
module post_code_capture_buffer_core
    import pcc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = PCC_RING_DEPTH,
    parameter int unsigned MAX_READ   = PCC_MAX_READ
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcc_in_if.sink      i_in,
    pcc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam logic REG_PSB = 1'b0;
    localparam logic REG_ABL = 1'b1;

    logic [15:0]   r_psb_prefix;
    logic [15:0]   r_abl_prefix;
    logic          cfg_wr;

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    t_job          q_in;
    t_job          q_out;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [AW-1:0] wp;
    logic          rd_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psb_prefix <= PSB_PREFIX_RST;
            r_abl_prefix <= ABL_PREFIX_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PSB) begin
                r_psb_prefix <= pwdata[15:0];
            end else begin
                r_abl_prefix <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            prdata = {16'b0, (paddr[2] == REG_ABL) ? r_abl_prefix : r_psb_prefix};
        end
    end

    pcc_front #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_wp        (wp),
        .i_rd_done   (rd_done)
    );

    pcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    pcc_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .i_job        (q_out),
        .i_wp         (wp),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .i_psb_prefix (r_psb_prefix),
        .i_abl_prefix (r_abl_prefix),
        .o_out        (o_out),
        .o_rd_done    (rd_done)
    );
endmodule

// ===== rtl/pcc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the post code ring.
module pcc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pcc_queue.sv =====
// Short job queue between the command front end and the result back end.
// Depends on pcc_pkg for the job type and the queue depth.
module pcc_queue
    import pcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);
    localparam int unsigned QAW = $clog2(PCC_QUEUE_DEPTH);
    localparam int unsigned QCW = $clog2(PCC_QUEUE_DEPTH + 1);
    localparam logic [QCW-1:0] QFULL = QCW'(PCC_QUEUE_DEPTH);

    t_job           r_mem [PCC_QUEUE_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic [QCW-1:0] n_cnt;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == QFULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
endmodule

// ===== rtl/pcc_front.sv =====
// Command front end: assembles post codes, keeps ring pointer, length and seen flag,
// writes the ring and queues one job per result-producing beat. Depends on pcc_pkg, pcc_if.
module pcc_front
    import pcc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = PCC_RING_DEPTH,
    parameter int unsigned MAX_READ   = PCC_MAX_READ
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcc_in_if.sink                        i_in,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_job                          o_job,
    output logic                          o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_waddr,
    output logic [31:0]                   o_ram_wdata,
    output logic [$clog2(RING_DEPTH)-1:0] o_wp,
    input  logic                          i_rd_done
);
    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned SW = ((CW > 8) ? CW : 8) + 1;
    localparam int unsigned PW = $clog2(PCC_QUEUE_DEPTH + 2);
    localparam logic [AW-1:0] WP_MAX  = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] SC_MAX  = CW'(RING_DEPTH);
    localparam logic [6:0]    MAXR    = 7'(MAX_READ);
    localparam logic [PW-1:0] PEND_MX = PW'(PCC_QUEUE_DEPTH + 1);

    logic [31:0]   r_acc;
    logic [31:0]   n_acc;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [CW-1:0] r_sc;
    logic [CW-1:0] n_sc;
    logic          r_seen;
    logic          n_seen;
    logic [PW-1:0] r_rd_pend;
    logic [PW-1:0] n_rd_pend;

    logic          accept;
    logic          lane_last;
    logic [31:0]   acc_or;
    logic [6:0]    count_sat;
    logic [SW-1:0] sc_x;
    logic [SW-1:0] st_x;
    logic [SW-1:0] avail;
    logic [6:0]    n_read;
    logic          read_empty;
    logic [CW+8:0] hist_x;
    logic          push_read;

    assign lane_last = (i_in.cmd == CMD_SNOOP) && (i_in.port_index == LANE_LAST);
    assign i_in.ready = !i_q_full && !(lane_last && r_rd_pend != '0);
    assign accept = i_in.valid && i_in.ready;

    assign acc_or = (i_in.port_index[3:2] == 2'b00)
                  ? (r_acc | ({24'b0, i_in.snoop_byte} << {i_in.port_index[1:0], 3'b000}))
                  : r_acc;

    assign count_sat  = (i_in.read_count > MAXR) ? MAXR : i_in.read_count;
    assign sc_x       = SW'(r_sc);
    assign st_x       = SW'(i_in.read_start);
    assign avail      = sc_x - st_x;
    assign read_empty = (st_x >= sc_x) || (count_sat == '0);
    assign n_read     = (avail > SW'(count_sat)) ? count_sat : avail[6:0];
    assign hist_x     = {9'b0, n_sc};

    always_comb begin
        n_acc    = r_acc;
        n_wp     = r_wp;
        n_sc     = r_sc;
        n_seen   = r_seen;
        o_push   = 1'b0;
        o_ram_we = 1'b0;
        o_job    = '0;
        if (accept) begin
            case (t_cmd'(i_in.cmd))
                CMD_SNOOP: begin
                    n_seen = 1'b1;
                    n_acc  = acc_or;
                    if (lane_last) begin
                        o_ram_we = 1'b1;
                        o_push   = 1'b1;
                        n_acc    = '0;
                        n_wp     = (r_wp == WP_MAX) ? '0 : r_wp + 1'b1;
                        if (r_sc < SC_MAX) begin
                            n_sc = r_sc + 1'b1;
                        end
                        o_job.kind = KIND_CODE;
                        o_job.code = acc_or;
                        o_job.seen = 1'b1;
                    end
                end
                CMD_READ: begin
                    o_push      = 1'b1;
                    o_job.kind  = read_empty ? KIND_EMPTY : KIND_HIST;
                    o_job.start = i_in.read_start;
                    o_job.count = n_read;
                    o_job.seen  = r_seen;
                end
                CMD_CLR_LEN: begin
                    n_sc = '0;
                end
                default: begin
                    n_seen = 1'b0;
                end
            endcase
        end
        o_job.hist = hist_x[8:0];
    end

    assign push_read = o_push && (o_job.kind == KIND_HIST);

    always_comb begin
        case ({push_read, i_rd_done})
            2'b10:   n_rd_pend = r_rd_pend + 1'b1;
            2'b01:   n_rd_pend = r_rd_pend - 1'b1;
            default: n_rd_pend = r_rd_pend;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_wp      <= '0;
            r_sc      <= '0;
            r_seen    <= 1'b0;
            r_rd_pend <= '0;
        end else begin
            r_acc     <= n_acc;
            r_wp      <= n_wp;
            r_sc      <= n_sc;
            r_seen    <= n_seen;
            r_rd_pend <= n_rd_pend;
        end
    end

    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = acc_or;
    assign o_wp        = r_wp;

    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> r_rd_pend == '0)
        else $error("ring written while a history read is outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend <= PEND_MX)
        else $error("outstanding read count exceeds queue capacity");

    a_done_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_done |-> r_rd_pend != '0)
        else $error("read completion without an outstanding read");
endmodule

// ===== rtl/pcc_back.sv =====
// Result back end: takes queued jobs, reads history entries from the ring one per beat,
// classifies each code and holds it in the output register. Depends on pcc_pkg, pcc_if.
module pcc_back
    import pcc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = PCC_RING_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  t_job                          i_job,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wp,
    output logic                          o_ram_re,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_raddr,
    input  logic [31:0]                   i_ram_rdata,
    input  logic [15:0]                   i_psb_prefix,
    input  logic [15:0]                   i_abl_prefix,
    pcc_out_if.source                     o_out,
    output logic                          o_rd_done
);
    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned IW = ((AW + 1 > 9) ? AW + 1 : 9) + 1;
    localparam logic [AW-1:0] WP_MAX = AW'(RING_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_X = IW'(RING_DEPTH);

    logic          r_act;
    t_job          r_job;
    logic [6:0]    r_left;
    logic [AW-1:0] r_idx;

    logic          r_d_vld;
    t_kind         r_d_kind;
    logic [31:0]   r_d_code;
    logic [8:0]    r_d_hist;
    logic          r_d_seen;
    logic          r_d_last;

    logic          r_o_vld;
    t_kind         r_o_kind;
    logic [31:0]   r_o_code;
    t_cls          r_o_cls;
    logic [8:0]    r_o_hist;
    logic          r_o_seen;
    logic          r_o_last;

    logic          out_free;
    logic          d_free;
    logic          issue;
    logic          issue_last;
    logic          is_hist;
    logic [IW-1:0] wp_x;
    logic [IW-1:0] back_x;
    logic [IW-1:0] first_x;
    logic [31:0]   code_sel;
    t_cls          cls_w;

    assign out_free   = !r_o_vld || o_out.ready;
    assign d_free     = !r_d_vld || out_free;
    assign issue      = r_act && d_free;
    assign is_hist    = (r_job.kind == KIND_HIST);
    assign issue_last = !is_hist || (r_left == 7'd1);
    assign o_ram_re   = issue && is_hist;
    assign o_ram_raddr = r_idx;
    assign o_rd_done  = issue && is_hist && (r_left == 7'd1);
    assign o_pop      = !i_q_empty && (!r_act || (issue && issue_last));

    assign wp_x    = IW'(i_wp);
    assign back_x  = IW'(i_job.start) + 1'b1;
    assign first_x = (wp_x >= back_x) ? (wp_x - back_x) : (wp_x + DEPTH_X - back_x);

    assign code_sel = (r_d_kind == KIND_HIST) ? i_ram_rdata : r_d_code;

    always_comb begin
        cls_w = classify(code_sel, i_psb_prefix, i_abl_prefix);
        if (r_d_kind == KIND_EMPTY) begin
            cls_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (issue && issue_last) begin
                r_act <= 1'b0;
            end
            if (d_free) begin
                r_d_vld <= issue;
            end
            if (out_free) begin
                r_o_vld <= r_d_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_left <= i_job.count;
            r_idx  <= first_x[AW-1:0];
        end else if (issue && is_hist) begin
            r_left <= r_left - 1'b1;
            r_idx  <= (r_idx == '0) ? WP_MAX : r_idx - 1'b1;
        end
        if (d_free) begin
            r_d_kind <= r_job.kind;
            r_d_code <= r_job.code;
            r_d_hist <= r_job.hist;
            r_d_seen <= r_job.seen;
            r_d_last <= issue_last;
        end
        if (out_free) begin
            r_o_kind <= r_d_kind;
            r_o_code <= code_sel;
            r_o_cls  <= cls_w;
            r_o_hist <= r_d_hist;
            r_o_seen <= r_d_seen;
            r_o_last <= r_d_last;
        end
    end

    assign o_out.valid          = r_o_vld;
    assign o_out.kind           = r_o_kind;
    assign o_out.code_word      = r_o_code;
    assign o_out.error_class    = r_o_cls.cls;
    assign o_out.err_code       = r_o_cls.ecode;
    assign o_out.history_length = r_o_hist;
    assign o_out.seen_flag      = r_o_seen;
    assign o_out.last           = r_o_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_kind == KIND_EMPTY) |-> r_o_last)
        else $error("empty read result without last marker");

    a_hist_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && is_hist) |-> r_left != '0)
        else $error("history job active with no entries left");

    a_rdata_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld && r_d_kind == KIND_HIST && !out_free) |=> $stable(i_ram_rdata))
        else $error("ring read data changed while its beat was stalled");
endmodule
